FILE: hw/rtl/wre_pkg.sv
// Shared types and constants for the watchpoint range encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package wre_pkg;

    localparam int ADDR_W          = 64;
    localparam int SIZE_LOG2_W     = 5;
    localparam int CTRL_W          = 32;
    localparam int BSEL_W          = 8;
    localparam int SEL_W           = 2;
    localparam int MAX_MASK_BITS_DEF = 31;

    // Sizes up to eight bytes use byte select; larger ones use the mask field.
    localparam logic [SIZE_LOG2_W-1:0] SMALL_LOG2_MAX = 5'd3;
    localparam logic [BSEL_W-1:0]      BSEL_FULL      = 8'hff;
    localparam int                     VALREG_ALIGN   = 3;

    // APB register map.
    localparam int  PADDR_W      = 3;
    localparam int  PDATA_W      = 32;
    localparam logic REG_PRIVILEGE = 1'b0;
    localparam logic REG_ACCESS    = 1'b1;
    localparam logic [SEL_W-1:0] PRIVILEGE_RESET = 2'd2;
    localparam logic [SEL_W-1:0] ACCESS_RESET    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic grow_step;
        logic load_out;
        logic out_err;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic inverted;
        logic scan_more;
        logic grow_more;
        logic k_at_max;
    } status_t;

endpackage

FILE: hw/rtl/watchpoint_range_encoder.sv
// Top level of the watchpoint range encoder: APB register file, sequencer and
// datapath. Depends on wre_pkg, wre_ctrl and wre_dp.
//
// The block takes a request holding an inclusive byte range [range_low,
// range_high] and returns one result: the watch address, the value register
// address, log2 of a covering power-of-two size, a watchpoint control word and
// an error flag. The exponent starts at the bit length of (high - low), found by
// shifting the span right one bit per cycle, and then grows one step per cycle
// while the aligned base plus the size stays below range_high; each grow step
// costs one 64-bit subtract and compare. Both phases advance the same exponent
// counter. One request is in flight at a time; a finished result sits in an
// output register, so a new request is accepted while the previous result
// still waits for m_ready. An inverted range, or one needing an exponent above
// MAX_MASK_BITS, returns range_error with all other fields zero.
// The privilege and access selects are written through the APB port at byte
// addresses 0 and 4, reset to 2 and 3, and should only be changed while idle.
module watchpoint_range_encoder #(
    parameter int MAX_MASK_BITS = wre_pkg::MAX_MASK_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wre_pkg::ADDR_W-1:0]          s_range_low,
    input  logic [wre_pkg::ADDR_W-1:0]          s_range_high,
    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wre_pkg::ADDR_W-1:0]          m_watch_address,
    output logic [wre_pkg::ADDR_W-1:0]          m_aligned_address,
    output logic [wre_pkg::SIZE_LOG2_W-1:0]     m_size_log2,
    output logic [wre_pkg::CTRL_W-1:0]          m_control_word,
    output logic                                m_range_error,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wre_pkg::PADDR_W-1:0]         paddr,
    input  logic [wre_pkg::PDATA_W-1:0]         pwdata,
    output logic [wre_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    logic [wre_pkg::SEL_W-1:0] privilege_reg, access_reg;
    logic                      cfg_write;
    logic                      reg_index;
    wre_pkg::cmd_t             cmd;
    wre_pkg::status_t          status;

    // Registers sit at byte addresses 0 and 4; address bit 2 picks one.
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            privilege_reg <= wre_pkg::PRIVILEGE_RESET;
            access_reg    <= wre_pkg::ACCESS_RESET;
        end else if (cfg_write) begin
            if (reg_index == wre_pkg::REG_PRIVILEGE) begin
                privilege_reg <= pwdata[wre_pkg::SEL_W-1:0];
            end else begin
                access_reg <= pwdata[wre_pkg::SEL_W-1:0];
            end
        end
    end

    // Read data: the selected register, zero extended.
    always_comb begin
        if (reg_index == wre_pkg::REG_ACCESS) begin
            prdata = wre_pkg::PDATA_W'(access_reg);
        end else begin
            prdata = wre_pkg::PDATA_W'(privilege_reg);
        end
    end

    wre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wre_dp #(
        .MAX_MASK_BITS (MAX_MASK_BITS)
    ) u_dp (
        .aclk              (aclk),
        .cmd               (cmd),
        .status            (status),
        .s_range_low       (s_range_low),
        .s_range_high      (s_range_high),
        .privilege_select  (privilege_reg),
        .access_select     (access_reg),
        .m_watch_address   (m_watch_address),
        .m_aligned_address (m_aligned_address),
        .m_size_log2       (m_size_log2),
        .m_control_word    (m_control_word),
        .m_range_error     (m_range_error)
    );

endmodule

FILE: hw/rtl/wre_ctrl.sv
// Sequencer for the watchpoint range encoder.
// Depends on wre_pkg; drives the datapath through wre_pkg::cmd_t.
module wre_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  wre_pkg::status_t status,
    output wre_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_GROW   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    err_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Bit length of the span gives the starting exponent.
                if (status.inverted) begin
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if (status.scan_more) begin
                    if (status.k_at_max) begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        cmd.scan_step = 1'b1;
                    end
                end else begin
                    state_next = ST_GROW;
                end
            end
            ST_GROW: begin
                if (status.grow_more) begin
                    if (status.k_at_max) begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        cmd.grow_step = 1'b1;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_err  = err_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hw/rtl/wre_dp.sv
// Datapath for the watchpoint range encoder: span shifter, size and mask
// registers, grow compare and result registers. Depends on wre_pkg.
module wre_dp #(
    parameter int MAX_MASK_BITS = wre_pkg::MAX_MASK_BITS_DEF
) (
    input  logic                                aclk,
    input  wre_pkg::cmd_t                       cmd,
    output wre_pkg::status_t                    status,
    input  logic [wre_pkg::ADDR_W-1:0]          s_range_low,
    input  logic [wre_pkg::ADDR_W-1:0]          s_range_high,
    input  logic [wre_pkg::SEL_W-1:0]           privilege_select,
    input  logic [wre_pkg::SEL_W-1:0]           access_select,
    output logic [wre_pkg::ADDR_W-1:0]          m_watch_address,
    output logic [wre_pkg::ADDR_W-1:0]          m_aligned_address,
    output logic [wre_pkg::SIZE_LOG2_W-1:0]     m_size_log2,
    output logic [wre_pkg::CTRL_W-1:0]          m_control_word,
    output logic                                m_range_error
);

    localparam int AW = wre_pkg::ADDR_W;
    localparam int KW = wre_pkg::SIZE_LOG2_W;
    localparam int BW = wre_pkg::BSEL_W;

    logic [AW-1:0] lo_reg, hi_reg, span_reg, size_reg, mask_reg;
    logic [KW-1:0] k_reg;
    logic          inv_reg;

    logic [AW-1:0] aligned, diff;
    logic [BW-1:0] ones, bsel;
    logic [2*BW-1:0] bsel_wide;
    logic          sub_dword;

    logic [AW-1:0] watch_reg, valreg_reg;
    logic [KW-1:0] size_log2_reg;
    logic [wre_pkg::CTRL_W-1:0] ctrl_reg;
    logic          err_out_reg;

    assign aligned = lo_reg & ~mask_reg;
    assign diff    = hi_reg - aligned;

    assign status.inverted  = inv_reg;
    assign status.scan_more = (span_reg != '0);
    assign status.grow_more = (size_reg < diff);
    assign status.k_at_max  = (k_reg == KW'(MAX_MASK_BITS));

    // Byte-select pattern for sizes of one to eight bytes.
    always_comb begin
        case (k_reg)
            5'd0:    ones = 8'h01;
            5'd1:    ones = 8'h03;
            5'd2:    ones = 8'h0f;
            default: ones = wre_pkg::BSEL_FULL;
        endcase
    end

    assign sub_dword = (k_reg <= wre_pkg::SMALL_LOG2_MAX);
    assign bsel_wide = {{BW{1'b0}}, ones} << aligned[2:0];
    assign bsel      = sub_dword ? bsel_wide[BW-1:0] : wre_pkg::BSEL_FULL;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg   <= s_range_low;
            hi_reg   <= s_range_high;
            span_reg <= s_range_high - s_range_low;
            inv_reg  <= (s_range_high < s_range_low);
            size_reg <= AW'(1);
            mask_reg <= '0;
            k_reg    <= '0;
        end else if (cmd.scan_step || cmd.grow_step) begin
            span_reg <= span_reg >> 1;
            size_reg <= size_reg << 1;
            mask_reg <= {mask_reg[AW-2:0], 1'b1};
            k_reg    <= k_reg + KW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            err_out_reg <= cmd.out_err;
            if (cmd.out_err) begin
                watch_reg     <= '0;
                valreg_reg    <= '0;
                size_log2_reg <= '0;
                ctrl_reg      <= '0;
            end else begin
                size_log2_reg <= k_reg;
                if (sub_dword) begin
                    watch_reg  <= lo_reg;
                    valreg_reg <= {lo_reg[AW-1:wre_pkg::VALREG_ALIGN],
                                   {wre_pkg::VALREG_ALIGN{1'b0}}};
                end else begin
                    watch_reg  <= aligned;
                    valreg_reg <= aligned;
                end
                ctrl_reg <= {3'b000, (sub_dword ? {KW{1'b0}} : k_reg), 11'b0, bsel,
                             access_select, privilege_select, 1'b1};
            end
        end
    end

    assign m_watch_address   = watch_reg;
    assign m_aligned_address = valreg_reg;
    assign m_size_log2       = size_log2_reg;
    assign m_control_word    = ctrl_reg;
    assign m_range_error     = err_out_reg;

endmodule

FILE: verif/tb_watchpoint_range_encoder.sv
// Self-checking testbench for watchpoint_range_encoder: scoreboard with its own range encoder
// model, request and result drivers with random idling, and APB register writes per phase.
// Depends on wre_pkg and the watchpoint_range_encoder RTL.

// Expected result of one request, with the request kept for messages.
typedef struct {
    logic [wre_pkg::ADDR_W-1:0]      range_low;
    logic [wre_pkg::ADDR_W-1:0]      range_high;
    logic [wre_pkg::ADDR_W-1:0]      watch_address;
    logic [wre_pkg::ADDR_W-1:0]      aligned_address;
    logic [wre_pkg::SIZE_LOG2_W-1:0] size_log2;
    logic [wre_pkg::CTRL_W-1:0]      control_word;
    logic                            range_error;
} range_encoding_t;

class wre_scoreboard;
    localparam int MASK_LIMIT = wre_pkg::MAX_MASK_BITS_DEF;

    range_encoding_t           encodings_due[$];
    int                        mismatches = 0;
    logic [wre_pkg::SEL_W-1:0] privilege_sel = wre_pkg::PRIVILEGE_RESET;
    logic [wre_pkg::SEL_W-1:0] access_sel    = wre_pkg::ACCESS_RESET;

    task report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Covering size: exact ceil log2 of the byte count, then grow while the
    // aligned block ends short of range_high (one byte short is accepted).
    function range_encoding_t encode_range(input logic [63:0] lo, input logic [63:0] hi);
        range_encoding_t r;
        logic [63:0]     span;
        logic [63:0]     size;
        logic [63:0]     base;
        logic [63:0]     bsel;
        logic [4:0]      mask;
        int              k;
        bit              fail;
        r.range_low       = lo;
        r.range_high      = hi;
        r.watch_address   = '0;
        r.aligned_address = '0;
        r.size_log2       = '0;
        r.control_word    = '0;
        r.range_error     = 1'b0;
        if (hi < lo) begin
            r.range_error = 1'b1;
            return r;
        end
        span = hi - lo;
        if (&span) begin
            k = 64;
        end else begin
            k = 0;
            while (k < 64 && (64'd1 << k) < span + 64'd1) k++;
        end
        fail = (k > MASK_LIMIT);
        if (!fail) begin
            size = 64'd1 << k;
            base = lo & ~(size - 64'd1);
            while (!fail && size < hi - base) begin
                k++;
                if (k > MASK_LIMIT) begin
                    fail = 1'b1;
                end else begin
                    size = 64'd1 << k;
                    base = lo & ~(size - 64'd1);
                end
            end
        end
        if (fail) begin
            r.range_error = 1'b1;
            return r;
        end
        size = 64'd1 << k;
        base = lo & ~(size - 64'd1);
        if (k <= int'(wre_pkg::SMALL_LOG2_MAX)) begin
            // Small sizes watch the exact address and pick bytes in the dword.
            if (k == 0) bsel = 64'd1 << lo[2:0];
            else        bsel = ((64'd1 << size) - 64'd1) << base[2:0];
            mask = '0;
            r.watch_address   = lo;
            r.aligned_address = (lo >> wre_pkg::VALREG_ALIGN) << wre_pkg::VALREG_ALIGN;
        end else begin
            bsel = {56'd0, wre_pkg::BSEL_FULL};
            mask = k[4:0];
            r.watch_address   = base;
            r.aligned_address = base;
        end
        r.size_log2    = k[4:0];
        r.control_word = {3'd0, mask, 11'd0, bsel[7:0], access_sel, privilege_sel, 1'b1};
        return r;
    endfunction

    function void note_request(input logic [63:0] lo, input logic [63:0] hi);
        encodings_due.insert(encodings_due.size(), encode_range(lo, hi));
    endfunction

    task check_result(input logic [63:0] watch, input logic [63:0] aligned,
                      input logic [4:0] size_log2, input logic [31:0] ctrl,
                      input logic err);
        range_encoding_t want;
        if (encodings_due.size() == 0) begin
            report_mismatch($sformatf("result with no request waiting, watch %h", watch));
            return;
        end
        want = encodings_due.pop_front();
        if (watch !== want.watch_address)
            report_mismatch($sformatf("[%h,%h] watch_address %h, want %h",
                want.range_low, want.range_high, watch, want.watch_address));
        if (aligned !== want.aligned_address)
            report_mismatch($sformatf("[%h,%h] aligned_address %h, want %h",
                want.range_low, want.range_high, aligned, want.aligned_address));
        if (size_log2 !== want.size_log2)
            report_mismatch($sformatf("[%h,%h] size_log2 %0d, want %0d",
                want.range_low, want.range_high, size_log2, want.size_log2));
        if (ctrl !== want.control_word)
            report_mismatch($sformatf("[%h,%h] control_word %h, want %h",
                want.range_low, want.range_high, ctrl, want.control_word));
        if (err !== want.range_error)
            report_mismatch($sformatf("[%h,%h] range_error %b, want %b",
                want.range_low, want.range_high, err, want.range_error));
    endtask
endclass

module tb_watchpoint_range_encoder;

    // Worst request: the longest exponent search, the longest sender gap and the
    // longest result stall. The limit is several times that over all requests.
    localparam int LIMIT_CYCLES   = 800000;
    localparam int DRAIN_CYCLES   = wre_pkg::MAX_MASK_BITS_DEF + 8;
    localparam int PHASES         = 8;
    localparam int RANDOM_PER_PHASE = 203;
    localparam logic [wre_pkg::PADDR_W-1:0] ADDR_PRIVILEGE = {wre_pkg::REG_PRIVILEGE, 2'b00};
    localparam logic [wre_pkg::PADDR_W-1:0] ADDR_ACCESS    = {wre_pkg::REG_ACCESS, 2'b00};
    localparam logic [63:0] TOP = '1;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [wre_pkg::ADDR_W-1:0]      s_range_low = '0;
    logic [wre_pkg::ADDR_W-1:0]      s_range_high = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [wre_pkg::ADDR_W-1:0]      m_watch_address;
    logic [wre_pkg::ADDR_W-1:0]      m_aligned_address;
    logic [wre_pkg::SIZE_LOG2_W-1:0] m_size_log2;
    logic [wre_pkg::CTRL_W-1:0]      m_control_word;
    logic                            m_range_error;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [wre_pkg::PADDR_W-1:0]     paddr = '0;
    logic [wre_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [wre_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    wre_scoreboard sb = new;
    int            cycle_count = 0;
    // When set, neither side idles; used for one full phase of back-to-back traffic.
    bit            quiet = 1'b0;

    watchpoint_range_encoder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_range_low       (s_range_low),
        .s_range_high      (s_range_high),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_watch_address   (m_watch_address),
        .m_aligned_address (m_aligned_address),
        .m_size_log2       (m_size_log2),
        .m_control_word    (m_control_word),
        .m_range_error     (m_range_error),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor. All stimulus changes with nonblocking assignments at the clock
    // edge, so the values read here are the ones the block saw at this edge.
    // Each accepted request is predicted using the register values the
    // testbench last wrote; the registers only change while the block is idle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_range_low, s_range_high);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_watch_address, m_aligned_address, m_size_log2,
                                m_control_word, m_range_error);
            end
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // The result side stalls for random stretches, independent of the sender,
    // so stalls land on every stage of the block's work.
    initial begin : result_ready_driver
        int n;
        forever begin
            @(posedge aclk);
            n = idle_gap();
            if (n == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Sends one request and returns at the edge where it was accepted. Valid
    // is only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic send_range(input logic [63:0] lo, input logic [63:0] hi);
        int n;
        n = idle_gap();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_range_low  <= lo;
        s_range_high <= hi;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic apb_write(input logic [wre_pkg::PADDR_W-1:0] addr,
                             input logic [wre_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        // pready is always high, so the register takes the value at this edge.
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PRIVILEGE) sb.privilege_sel = data[wre_pkg::SEL_W-1:0];
        else if (addr == ADDR_ACCESS) sb.access_sel = data[wre_pkg::SEL_W-1:0];
    endtask

    task automatic apb_read_check(input logic [wre_pkg::PADDR_W-1:0] addr,
                                  input logic [wre_pkg::SEL_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {{(wre_pkg::PDATA_W-wre_pkg::SEL_W){1'b0}}, want})
            sb.report_mismatch($sformatf("register at %0d reads %h, want %h",
                                         addr, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers may only change while nothing is in flight. Every request
    // yields a result, so an empty scoreboard means the block is idle. The
    // first edge lets the monitor note a request accepted at the caller's edge.
    task automatic wait_all_results();
        @(posedge aclk);
        while (sb.encodings_due.size() != 0) @(posedge aclk);
    endtask

    // Upper data bits are random to show that only the select bits are kept.
    task automatic program_selects(input logic [wre_pkg::SEL_W-1:0] priv,
                                   input logic [wre_pkg::SEL_W-1:0] acc);
        apb_write(ADDR_PRIVILEGE, {30'($urandom_range(0, 32'h3fff_ffff)), priv});
        apb_write(ADDR_ACCESS, {30'($urandom_range(0, 32'h3fff_ffff)), acc});
        apb_read_check(ADDR_PRIVILEGE, priv);
        apb_read_check(ADDR_ACCESS, acc);
    endtask

    // Hand-picked ranges: every size class, both byte-select halves, the kept
    // off-by-one cover, the exponent limit hit at the start and while growing,
    // a full 64-bit span, inverted ranges, and the very top of the address space.
    task automatic run_directed();
        send_range(64'd0, 64'd0);
        send_range(64'd7, 64'd7);
        send_range(64'd5, 64'd5);
        send_range(64'd0, 64'd1);
        send_range(64'd2, 64'd3);
        send_range(64'd3, 64'd4);
        send_range(64'd4, 64'd7);
        send_range(64'd0, 64'd7);
        send_range(64'd1, 64'd8);
        send_range(64'd8, 64'd16);
        send_range(64'd0, 64'd9);
        send_range(64'h1000, 64'h1fff);
        send_range(64'd0, 64'h7fff_ffff);
        send_range(64'd0, 64'h8000_0000);
        send_range(64'd1, 64'h8000_0000);
        send_range(64'h7fff_ffff, 64'h8000_0000);
        send_range(64'h7fff_fff0, 64'h8000_0010);
        send_range(64'd0, TOP);
        send_range(TOP, TOP);
        send_range(TOP - 64'd1, TOP);
        send_range(64'd5, 64'd4);
        send_range(TOP, 64'd0);
        send_range(64'd1, 64'd0);
        send_range(64'hffff_ffff_0000_0000, 64'hffff_ffff_7fff_ffff);
        send_range(64'haaaa_aaaa_5555_5555, 64'haaaa_aaaa_5555_55aa);
    endtask

    // Random range. Most are valid ranges whose span spreads evenly over bit
    // lengths up to the mask limit, many of them on or near an alignment
    // boundary so the grow loop runs; the rest are tiny spans, oversized
    // spans and inverted ranges.
    task automatic pick_range(output logic [63:0] lo, output logic [63:0] hi);
        int          r;
        int          bits;
        int          j;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] span;
        r  = $urandom_range(0, 99);
        lo = rand64();
        if (r < 8) begin
            a  = rand64();
            b  = rand64();
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
            if (lo == hi) lo = lo + 64'd1;
            return;
        end
        if (r < 13) begin
            bits = $urandom_range(32, 64);
            if (bits == 64) span = rand64() | (64'd1 << 63);
            else span = (rand64() >> (64 - bits)) | (64'd1 << (bits - 1));
        end else if (r < 35) begin
            span = 64'($urandom_range(0, 15));
            lo   = (lo & ~64'hf) | 64'($urandom_range(0, 15));
        end else begin
            bits = $urandom_range(0, 31);
            span = (bits == 0) ? 64'd0 : (rand64() >> (64 - bits));
            if ($urandom_range(0, 1) == 1) begin
                j  = $urandom_range(0, 31);
                lo = ((lo >> j) << j) + 64'($urandom_range(0, 3));
            end
        end
        // Keep hi from wrapping; clamping also lands some ranges at the top.
        if (lo > ~span) lo = ~span;
        hi = lo + span;
    endtask

    task automatic run_random(input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        repeat (count) begin
            pick_range(lo, hi);
            send_range(lo, hi);
        end
    endtask

    initial begin : main_sequence
        logic [wre_pkg::SEL_W-1:0] priv;
        logic [wre_pkg::SEL_W-1:0] acc;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values first, then the directed ranges under them.
        apb_read_check(ADDR_PRIVILEGE, wre_pkg::PRIVILEGE_RESET);
        apb_read_check(ADDR_ACCESS, wre_pkg::ACCESS_RESET);
        run_directed();
        s_valid <= 1'b0;
        wait_all_results();

        // Each phase programs new selects while idle, then runs random ranges.
        // The first four cover both extremes and mixed values; phase three
        // runs with no idling on either side.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin priv = 2'd0; acc = 2'd0; end
                1: begin priv = 2'd3; acc = 2'd3; end
                2: begin priv = 2'd1; acc = 2'd2; end
                3: begin priv = 2'd3; acc = 2'd0; end
                default: begin
                    priv = wre_pkg::SEL_W'($urandom_range(0, 3));
                    acc  = wre_pkg::SEL_W'($urandom_range(0, 3));
                end
            endcase
            quiet = (p == 3);
            program_selects(priv, acc);
            run_random(RANDOM_PER_PHASE);
            s_valid <= 1'b0;
            wait_all_results();
        end

        quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.encodings_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
